@@ hdl/rrst_pkg.sv @@
// Shared constants and controller/datapath interface types of the server table.
`default_nettype none

package rrst_pkg;

  localparam int unsigned PORT_W          = 16;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned ENTRY_W         = PORT_W + ADDR_W;
  localparam int unsigned CMD_W           = 2;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned COUNT_OUT_W     = 5;
  localparam int unsigned MAX_SERVERS_DEF = 16;

  localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEST    = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SERVER = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                in_load;
    logic                append;
    logic                idx_clr;
    logic                idx_inc;
    logic                rd_scan;
    logic                rd_next;
    logic                rd_pick;
    logic                shift_wr;
    logic                dec_count;
    logic                load_out;
    logic                use_pick;
    logic [STATUS_W-1:0] res_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd_code;
    logic             full;
    logic             empty;
    logic             port_match;
    logic             scan_last;
    logic             shift_last;
    logic             out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/round_robin_server_table.sv @@
// Round-robin server table: ordered list of servers handed out in turn to requests.
//
// Input channel (in_valid_i / in_stall_o) carries one item: a command with a
// port and an address. Output channel (out_valid_o / out_stall_i) returns one
// result per item: status, chosen port and address, and the count afterwards.
// One item is worked on at a time; in_stall_o is high until the controller is
// back in idle. Register and unused commands, and any item on an empty table,
// go from dispatch straight to the result; a request first waits in a state of
// its own, since the table RAM has a registered read. An unregister reads the
// table one entry at a time until the port matches, then moves each later entry
// down one place with a read and then a write. The next item can be accepted in
// the cycle after its predecessor's result is loaded.
// The result sits in an output register; while the receiver stalls, the next
// item is still accepted and worked on, and waits only to load its result.
// Reset empties the table and sets the round-robin index to the first entry.
`default_nettype none

module round_robin_server_table #(
  parameter int unsigned MAX_SERVERS = rrst_pkg::MAX_SERVERS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [rrst_pkg::CMD_W-1:0]       command_i,
  input  wire logic [rrst_pkg::PORT_W-1:0]      server_port_i,
  input  wire logic [rrst_pkg::ADDR_W-1:0]      server_ip_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [rrst_pkg::STATUS_W-1:0]    status_o,
  output logic      [rrst_pkg::PORT_W-1:0]      chosen_port_o,
  output logic      [rrst_pkg::ADDR_W-1:0]      chosen_address_o,
  output logic      [rrst_pkg::COUNT_OUT_W-1:0] server_count_o
);

  import rrst_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  rrst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  rrst_dp #(
    .MaxServers(MAX_SERVERS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .command_i       (command_i),
    .server_port_i   (server_port_i),
    .server_ip_i     (server_ip_i),
    .cmd_i           (cmd),
    .st_o            (st),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .chosen_port_o   (chosen_port_o),
    .chosen_address_o(chosen_address_o),
    .server_count_o  (server_count_o)
  );

`ifndef NO_ASSERTIONS
  // An accepted item keeps the input side busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // Appending is never commanded on a full table.
  a_no_append_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.append |-> !st.full)
    else $error("append on a full table");

  // A removal never happens on an empty table.
  a_no_dec_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.dec_count |-> !st.empty)
    else $error("count decrement on an empty table");

  // Loading a result always presents it in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not valid");
`endif

endmodule

`default_nettype wire

@@ hdl/rrst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rrst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/rrst_ctrl.sv @@
// Controller state machine that sequences register, unregister and request items.
`default_nettype none

module rrst_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire rrst_pkg::dp_status_t  st_i,
  output rrst_pkg::dp_cmd_t          cmd_o
);

  import rrst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_REQ_DATA,
    S_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic                use_pick_q, use_pick_d;
  dp_cmd_t             cmd;

  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    use_pick_d   = use_pick_q;
    cmd          = '0;
    cmd.use_pick   = use_pick_q;
    cmd.res_status = res_status_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.in_load = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        use_pick_d   = 1'b0;
        res_status_d = STATUS_OK;
        state_d      = S_RESP;
        unique case (st_i.cmd_code)
          CMD_REGISTER: begin
            if (st_i.full) begin
              res_status_d = STATUS_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end
          CMD_UNREGISTER: begin
            if (st_i.empty) begin
              res_status_d = STATUS_NOT_FOUND;
            end else begin
              cmd.idx_clr = 1'b1;
              state_d     = S_SCAN_RD;
            end
          end
          CMD_REQUEST: begin
            if (st_i.empty) begin
              res_status_d = STATUS_NO_SERVER;
            end else begin
              cmd.rd_pick = 1'b1;
              use_pick_d  = 1'b1;
              state_d     = S_REQ_DATA;
            end
          end
          default: begin
            // The unused command code only reports the current count.
            res_status_d = STATUS_OK;
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_d     = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (st_i.port_match) begin
          if (st_i.scan_last) begin
            cmd.dec_count = 1'b1;
            state_d       = S_RESP;
          end else begin
            state_d = S_SHIFT_RD;
          end
        end else if (st_i.scan_last) begin
          res_status_d = STATUS_NOT_FOUND;
          state_d      = S_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
          state_d     = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.rd_next = 1'b1;
        state_d     = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (st_i.shift_last) begin
          cmd.dec_count = 1'b1;
          state_d       = S_RESP;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end
      S_REQ_DATA: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (st_i.out_free) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_status_q <= STATUS_OK;
      use_pick_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      res_status_q <= res_status_d;
      use_pick_q   <= use_pick_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o      = cmd;

endmodule

`default_nettype wire

@@ hdl/rrst_dp.sv @@
// Datapath: item registers, table RAM, count, round-robin index and result registers.
`default_nettype none

module rrst_dp #(
  parameter int unsigned MaxServers = rrst_pkg::MAX_SERVERS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [rrst_pkg::CMD_W-1:0]          command_i,
  input  wire logic [rrst_pkg::PORT_W-1:0]         server_port_i,
  input  wire logic [rrst_pkg::ADDR_W-1:0]         server_ip_i,
  input  wire rrst_pkg::dp_cmd_t                   cmd_i,
  output rrst_pkg::dp_status_t                     st_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [rrst_pkg::STATUS_W-1:0]       status_o,
  output logic      [rrst_pkg::PORT_W-1:0]         chosen_port_o,
  output logic      [rrst_pkg::ADDR_W-1:0]         chosen_address_o,
  output logic      [rrst_pkg::COUNT_OUT_W-1:0]    server_count_o
);

  import rrst_pkg::*;

  localparam int unsigned AW = $clog2(MaxServers);
  localparam int unsigned CW = $clog2(MaxServers + 1);

  // Current item.
  logic [CMD_W-1:0]  cmd_q;
  logic [PORT_W-1:0] port_q;
  logic [ADDR_W-1:0] addr_q;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] pick_q, pick_d;
  logic [AW-1:0] idx_q, idx_d;

  logic               out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [PORT_W-1:0]  out_port_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [COUNT_OUT_W-1:0] out_count_q;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [CW:0]   idx_p1, idx_p2;
  logic [CW-1:0] last_idx, pick_clamp;
  logic [AW-1:0] pick_sel;
  logic [31:0]   count_ext;

  assign idx_p1   = (CW + 1)'(idx_q) + (CW + 1)'(1);
  assign idx_p2   = (CW + 1)'(idx_q) + (CW + 1)'(2);
  assign last_idx = count_q - CW'(1);

  // Past the end after removals, the last entry is picked.
  assign pick_clamp = (CW'(pick_q) > last_idx) ? last_idx : CW'(pick_q);
  assign pick_sel   = pick_clamp[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      cmd_q  <= command_i;
      port_q <= server_port_i;
      addr_q <= server_ip_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.append) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.dec_count) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    pick_d = pick_q;
    if (cmd_i.rd_pick) begin
      if (pick_clamp == last_idx) begin
        pick_d = '0;
      end else begin
        pick_d = pick_sel + AW'(1);
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pick_q  <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      pick_q  <= pick_d;
      idx_q   <= idx_d;
    end
  end

  // Table storage: each entry is the port above the address.
  assign ram_we    = cmd_i.append | cmd_i.shift_wr;
  assign ram_waddr = cmd_i.shift_wr ? idx_q : count_q[AW-1:0];
  assign ram_wdata = cmd_i.shift_wr ? ram_rdata : {port_q, addr_q};
  assign ram_re    = cmd_i.rd_scan | cmd_i.rd_next | cmd_i.rd_pick;

  always_comb begin
    ram_raddr = idx_q;
    if (cmd_i.rd_next) begin
      ram_raddr = idx_p1[AW-1:0];
    end else if (cmd_i.rd_pick) begin
      ram_raddr = pick_sel;
    end
  end

  rrst_ram #(
    .Width(ENTRY_W),
    .Depth(MaxServers)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign count_ext = 32'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.res_status;
      out_port_q   <= cmd_i.use_pick ? ram_rdata[ENTRY_W-1:ADDR_W] : '0;
      out_addr_q   <= cmd_i.use_pick ? ram_rdata[ADDR_W-1:0] : '0;
      out_count_q  <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  assign st_o.cmd_code   = cmd_q;
  assign st_o.full       = (count_q >= CW'(MaxServers));
  assign st_o.empty      = (count_q == '0);
  assign st_o.port_match = (ram_rdata[ENTRY_W-1:ADDR_W] == port_q);
  assign st_o.scan_last  = (idx_p1 >= (CW + 1)'(count_q));
  assign st_o.shift_last = (idx_p2 >= (CW + 1)'(count_q));
  assign st_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign chosen_port_o    = out_port_q;
  assign chosen_address_o = out_addr_q;
  assign server_count_o   = out_count_q;

endmodule

`default_nettype wire
